// ===== rtl/pfe_pkg.sv =====
package pfe_pkg;

    localparam int WORD_W   = 32;
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 2;

    localparam int DEF_STACK_DEPTH = 16;

    localparam logic [CHAR_W-1:0] CH_END   = 8'h23;  // '#'
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [CHAR_W-1:0] CH_TIMES = 8'h2A;  // '*'
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;  // '/'

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_DIV_ZERO  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_WB
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_TAKE_PREV,
        CELL_TAKE_NEXT
    } cell_op_t;

endpackage

// ===== rtl/pfe_cell.sv =====
module pfe_cell (
    input  logic                        clk,
    input  pfe_pkg::cell_op_t           op,
    input  logic [pfe_pkg::WORD_W-1:0]  prev_word,
    input  logic [pfe_pkg::WORD_W-1:0]  next_word,
    output logic [pfe_pkg::WORD_W-1:0]  word
);

    logic [pfe_pkg::WORD_W-1:0] word_reg;
    logic [pfe_pkg::WORD_W-1:0] word_next;

    always_comb
    begin
        unique case (op)
            pfe_pkg::CELL_TAKE_PREV: word_next = prev_word;
            pfe_pkg::CELL_TAKE_NEXT: word_next = next_word;
            default:                 word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ===== rtl/pfe_div.sv =====
module pfe_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pfe_pkg::WORD_W-1:0]  dividend,
    input  logic [pfe_pkg::WORD_W-1:0]  divisor,
    output logic                        done,
    output logic [pfe_pkg::WORD_W-1:0]  quotient
);

    localparam int W     = pfe_pkg::WORD_W;
    localparam int CNT_W = $clog2(W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     dsr_reg, dsr_next;
    logic [W:0]       shifted;
    logic [W:0]       diff;

    // One restoring step per cycle, most significant quotient bit first.
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/postfix_expression_evaluator.sv =====
// Postfix expression evaluator.
// Input channel: in_valid / in_stall with char_code, one ASCII character per
// request. Digits push their value, '+', '-', '*', '/' combine the top two
// words, any other symbol keeps the left operand, and '#' closes the
// expression. Output channel: out_valid / out_stall with value and status;
// one request leaves for every '#', from the output register loaded as it is taken.
// Operations: a digit, '#', '+', '-', other symbols and division by zero are
// done straight from the idle state; '*' passes through multiply, then write
// back; '/' runs operand setup, the 32-step restoring divider and the write
// back into the stack. No new character is taken until the last is done.
// The stack is a chain of word cells; a push shifts every word one cell down
// and a pop shifts it up, so only the top two cells are ever read.
// Reset clears the stack count, the error latch, the controller and the
// output valid flag; the stack words themselves need no reset.
// The finished result sits in an output register, so characters keep flowing
// while the receiver stalls; only a further '#' waits until that result has
// been taken.
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = pfe_pkg::DEF_STACK_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pfe_pkg::CHAR_W-1:0]    char_code,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pfe_pkg::WORD_W-1:0]    value,
    output logic [pfe_pkg::STATUS_W-1:0]  status
);

    localparam int W    = pfe_pkg::WORD_W;
    localparam int SP_W = $clog2(STACK_DEPTH + 1);

    pfe_pkg::state_t state_reg, state_next;

    logic [SP_W-1:0]             sp_reg, sp_next;
    logic [pfe_pkg::STATUS_W-1:0] err_reg, err_next;
    logic                        out_valid_reg, out_valid_next;
    logic [W-1:0]                value_reg, value_next;
    logic [pfe_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [W-1:0]                left_reg, left_next;
    logic [W-1:0]                right_reg, right_next;
    logic [W-1:0]                res_reg, res_next;
    logic                        neg_reg, neg_next;

    logic [W-1:0]       words [STACK_DEPTH];
    pfe_pkg::cell_op_t  ops   [STACK_DEPTH];

    logic         accept;
    logic         is_digit, is_end, is_mul, is_div;
    logic [W-1:0] right_op, left_op;
    logic [W-1:0] push_val;
    logic         shift_down, load_top, shift_up;
    logic         div_start, div_done;
    logic [W-1:0] div_a, div_b, div_q;

    assign is_digit = (char_code >= pfe_pkg::CH_ZERO) && (char_code <= pfe_pkg::CH_NINE);
    assign is_end   = (char_code == pfe_pkg::CH_END);
    assign is_mul   = (char_code == pfe_pkg::CH_TIMES);
    assign is_div   = (char_code == pfe_pkg::CH_SLASH);

    // A new '#' must not overwrite a result that is still being stalled.
    assign in_stall = (state_reg != pfe_pkg::ST_IDLE)
                    || (out_valid_reg && out_stall && is_end);
    assign accept   = in_valid && !in_stall;

    // Missing operands read as zero.
    assign right_op = (sp_reg >= SP_W'(1)) ? words[0] : '0;
    assign left_op  = (sp_reg >= SP_W'(2)) ? words[1] : '0;

    assign div_a = left_op[W-1]  ? (~left_op + 1'b1)  : left_op;
    assign div_b = right_op[W-1] ? (~right_op + 1'b1) : right_op;

    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && out_stall;
        value_next     = value_reg;
        status_next    = status_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        res_next       = res_reg;
        neg_next       = neg_reg;
        shift_down     = 1'b0;
        load_top       = 1'b0;
        push_val       = res_reg;
        div_start      = 1'b0;

        unique case (state_reg)
            pfe_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_digit)
                    begin
                        if (sp_reg == SP_W'(STACK_DEPTH))
                        begin
                            if (err_reg == pfe_pkg::STAT_OK)
                                err_next = pfe_pkg::STAT_OVERFLOW;
                        end
                        else
                        begin
                            shift_down = 1'b1;
                            push_val   = W'(char_code - pfe_pkg::CH_ZERO);
                            sp_next    = sp_reg + 1'b1;
                        end
                    end
                    else if (is_end)
                    begin
                        out_valid_next = 1'b1;
                        value_next     = right_op;
                        if (err_reg != pfe_pkg::STAT_OK)
                            status_next = err_reg;
                        else if (sp_reg == '0)
                            status_next = pfe_pkg::STAT_UNDERFLOW;
                        else
                            status_next = pfe_pkg::STAT_OK;
                        sp_next  = '0;
                        err_next = pfe_pkg::STAT_OK;
                    end
                    else
                    begin
                        // Underflow is seen by the pops before any divide check.
                        if (err_reg == pfe_pkg::STAT_OK)
                        begin
                            if (sp_reg < SP_W'(2))
                                err_next = pfe_pkg::STAT_UNDERFLOW;
                            else if (is_div && right_op == '0)
                                err_next = pfe_pkg::STAT_DIV_ZERO;
                        end
                        left_next  = left_op;
                        right_next = right_op;
                        neg_next   = left_op[W-1] ^ right_op[W-1];
                        if (is_mul)
                            state_next = pfe_pkg::ST_MUL;
                        else if (is_div && right_op != '0)
                        begin
                            div_start  = 1'b1;
                            state_next = pfe_pkg::ST_DIV;
                        end
                        else
                        begin
                            load_top = 1'b1;
                            sp_next  = (sp_reg >= SP_W'(2)) ? sp_reg - 1'b1 : SP_W'(1);
                            if (char_code == pfe_pkg::CH_PLUS)
                                push_val = left_op + right_op;
                            else if (char_code == pfe_pkg::CH_MINUS)
                                push_val = left_op - right_op;
                            else if (is_div)
                                push_val = '0;
                            else
                                push_val = left_op;
                        end
                    end
                end
            end
            pfe_pkg::ST_MUL:
            begin
                res_next   = W'(left_reg * right_reg);
                state_next = pfe_pkg::ST_WB;
            end
            pfe_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    res_next   = neg_reg ? (~div_q + 1'b1) : div_q;
                    state_next = pfe_pkg::ST_WB;
                end
            end
            pfe_pkg::ST_WB:
            begin
                load_top   = 1'b1;
                push_val   = res_reg;
                sp_next    = (sp_reg >= SP_W'(2)) ? sp_reg - 1'b1 : SP_W'(1);
                state_next = pfe_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pfe_pkg::ST_IDLE;
            end
        endcase
    end

    assign shift_up = load_top && (sp_reg >= SP_W'(2));

    always_comb
    begin
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            if (shift_down)
                ops[i] = pfe_pkg::CELL_TAKE_PREV;
            else if (load_top && i == 0)
                ops[i] = pfe_pkg::CELL_TAKE_PREV;
            else if (shift_up)
                ops[i] = pfe_pkg::CELL_TAKE_NEXT;
            else
                ops[i] = pfe_pkg::CELL_HOLD;
        end
    end

    for (genvar g = 0; g < STACK_DEPTH; g++)
    begin : g_cell
        logic [W-1:0] prev_w;
        logic [W-1:0] next_w;
        if (g == 0)
        begin : g_top
            assign prev_w = push_val;
        end
        else
        begin : g_mid
            assign prev_w = words[g-1];
        end
        if (g == STACK_DEPTH - 1)
        begin : g_bot
            assign next_w = words[g];
        end
        else
        begin : g_inner
            assign next_w = words[g+1];
        end
        pfe_cell u_cell (
            .clk       (clk),
            .op        (ops[g]),
            .prev_word (prev_w),
            .next_word (next_w),
            .word      (words[g])
        );
    end

    pfe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfe_pkg::ST_IDLE;
            sp_reg        <= '0;
            err_reg       <= pfe_pkg::STAT_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        status_reg <= status_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        res_reg    <= res_next;
        neg_reg    <= neg_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != pfe_pkg::ST_IDLE) |-> in_stall)
        else $error("request taken while an operation is in progress");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == pfe_pkg::ST_DIV))
        else $error("divider finished outside of a division");

    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_end) |=> (out_valid_reg && sp_reg == '0 && err_reg == pfe_pkg::STAT_OK))
        else $error("end of expression did not produce a result and clear the stack");

endmodule
